@@ rtl/bda_pkg.sv @@
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, constants and the double-dabble step for the binary to
// decimal ascii converter.
// ----------------------------------------------------------------------------
package bda_pkg;

	typedef enum logic [1:0] {
		CMD_S16 = 2'd0,
		CMD_U16 = 2'd1,
		CMD_U32 = 2'd2
	} cmd_t;

	localparam int unsigned DIGITS     = 10;
	localparam int unsigned BCD_W      = 4 * DIGITS;
	localparam int unsigned BIN_W      = 32;
	localparam int unsigned STEPS_PER  = 8;
	localparam int unsigned RUN_MAX    = 11;
	localparam int unsigned CNT_W      = 4;

	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_MINUS  = 8'd45;
	localparam logic [7:0] CHAR_PLUS   = 8'd43;
	localparam logic [7:0] CHAR_NUL    = 8'd0;

	localparam logic [CNT_W-1:0] LEN_S16 = CNT_W'(7);
	localparam logic [CNT_W-1:0] LEN_U16 = CNT_W'(6);
	localparam logic [CNT_W-1:0] LEN_U32 = CNT_W'(11);

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
	} dd_t;

	// eight shift-and-add-three steps
	function automatic dd_t dabble8(input dd_t x);
		dd_t r;
		r = x;
		for (int s = 0; s < STEPS_PER; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (r.bcd[4*d +: 4] >= 4'd5) begin
					r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
				end
			end
			r = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		end
		return r;
	endfunction

endpackage

@@ rtl/binary_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts a 16-bit signed, 16-bit unsigned or 32-bit unsigned number into
// zero-padded ascii decimal, closed by a nul byte marked with tlast.
// ----------------------------------------------------------------------------
// A word is taken in, its magnitude formed in the first stage and turned into
// ten bcd digits by four double-dabble stages of eight steps each; the
// output stage then sends one byte per cycle while the receiver is ready. A
// signed word gives seven bytes (sign, five digits, nul), an unsigned 16-bit
// word six and an unsigned 32-bit word eleven; a word with command 3 is taken
// and gives nothing. The first byte leaves once the word has passed the first
// stage and the four dabble stages and is loaded. The output stage sets the
// rate; the next word is loaded in the cycle its predecessor's last byte goes.
module binary_to_decimal_ascii_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // command [1:0], value [33:2], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // char_byte [7:0]
	output logic        m_axis_tlast
);

	localparam int unsigned BUF_W = 8 * bda_pkg::RUN_MAX;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               adv1, adv2, adv3, adv4, adv5, load;
	bda_pkg::cmd_t      cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	bda_pkg::dd_t       dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	logic [BUF_W-1:0]   buf_q;
	logic [bda_pkg::CNT_W-1:0] cnt_q;

	bda_pkg::cmd_t      in_cmd;
	logic [31:0]        in_value;
	logic [15:0]        in_bits;
	logic               in_ok;
	logic               in_neg;
	logic [15:0]        in_mag16;
	logic [BUF_W-1:0]   load_buf;
	logic [bda_pkg::CNT_W-1:0] load_len;

	// pipeline flow
	assign load = (cnt_q == '0) || (m_axis_tready && cnt_q == bda_pkg::CNT_W'(1));
	assign adv5 = !v_s5 || load;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_axis_tready = adv1;

	// input decode
	always_comb begin
		in_cmd   = bda_pkg::cmd_t'(s_axis_tdata[1:0]);
		in_value = s_axis_tdata[33:2];
		in_bits  = in_value[15:0];
		case (in_cmd)
			bda_pkg::CMD_S16,
			bda_pkg::CMD_U16,
			bda_pkg::CMD_U32: in_ok = 1'b1;
			default:          in_ok = 1'b0;
		endcase
		in_neg   = (in_cmd == bda_pkg::CMD_S16) && in_bits[15];
		in_mag16 = in_neg ? (~in_bits + 16'd1) : in_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_axis_tvalid && in_ok;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1     <= in_cmd;
			neg_s1     <= in_neg;
			dd_s1.bcd  <= '0;
			dd_s1.bin  <= (in_cmd == bda_pkg::CMD_U32) ? in_value : {16'd0, in_mag16};
		end
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			neg_s2 <= neg_s1;
			dd_s2  <= bda_pkg::dabble8(dd_s1);
		end
		if (adv3) begin
			cmd_s3 <= cmd_s2;
			neg_s3 <= neg_s2;
			dd_s3  <= bda_pkg::dabble8(dd_s2);
		end
		if (adv4) begin
			cmd_s4 <= cmd_s3;
			neg_s4 <= neg_s3;
			dd_s4  <= bda_pkg::dabble8(dd_s3);
		end
		if (adv5) begin
			cmd_s5 <= cmd_s4;
			neg_s5 <= neg_s4;
			dd_s5  <= bda_pkg::dabble8(dd_s4);
		end
	end

	// byte run, first byte lowest
	always_comb begin
		load_buf = '0;
		case (cmd_s5)
			bda_pkg::CMD_S16: begin
				load_buf[7:0] = neg_s5 ? bda_pkg::CHAR_MINUS : bda_pkg::CHAR_PLUS;
				for (int i = 1; i <= 5; i++) begin
					load_buf[8*i +: 8] = {4'h3, dd_s5.bcd[4*(5-i) +: 4]};
				end
				load_len = bda_pkg::LEN_S16;
			end
			bda_pkg::CMD_U16: begin
				for (int i = 0; i < 5; i++) begin
					load_buf[8*i +: 8] = {4'h3, dd_s5.bcd[4*(4-i) +: 4]};
				end
				load_len = bda_pkg::LEN_U16;
			end
			default: begin
				for (int i = 0; i < 10; i++) begin
					load_buf[8*i +: 8] = {4'h3, dd_s5.bcd[4*(9-i) +: 4]};
				end
				load_len = bda_pkg::LEN_U32;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= v_s5 ? load_len : '0;
		end else if (m_axis_tready && cnt_q != '0) begin
			cnt_q <= cnt_q - bda_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= load_buf;
		end else if (m_axis_tready && cnt_q != '0) begin
			buf_q <= {8'h00, buf_q[BUF_W-1:8]};
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = buf_q[7:0];
	assign m_axis_tlast  = (cnt_q == bda_pkg::CNT_W'(1));

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bda_pkg::CNT_W'(bda_pkg::RUN_MAX))
		else $error("byte count out of range");

	a_last_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == bda_pkg::CHAR_NUL)
		else $error("last byte is not nul");

	a_body_not_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata != bda_pkg::CHAR_NUL)
		else $error("nul byte inside a run");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !load |=> v_s5 && $stable(dd_s5.bcd))
		else $error("waiting word lost in last stage");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast && !v_s5 |=> !m_axis_tvalid)
		else $error("byte sent without a word");
`endif

endmodule
